@@ design/dah_pkg.sv @@
// ---------------------------------------------------------------------------
// Distance and heading unit package
// Shared constants, register codes and the CORDIC arctangent table.
// ---------------------------------------------------------------------------
`default_nettype none

package dah_pkg;

    localparam int COORD_WIDTH_DEF     = 24;
    localparam int ANGLE_FRAC_BITS_DEF = 13;
    localparam int PRESCALE_BITS       = 24;
    localparam int CORDIC_STEPS        = 30;
    localparam int ACC_FRAC            = 30;
    localparam int ACC_WIDTH           = 34;
    localparam int CFG_IDX_WIDTH       = 2;

    localparam logic signed [ACC_WIDTH-1:0] HALF_PI_Q30 = 34'sd1686629713;

    typedef enum logic [CFG_IDX_WIDTH-1:0] {
        REG_OWN_X = 2'd0,
        REG_OWN_Y = 2'd1,
        REG_OWN_Z = 2'd2
    } t_reg_idx;

    function automatic logic signed [ACC_WIDTH-1:0] atan_q30(input int i);
        logic signed [ACC_WIDTH-1:0] v;
        unique case (i)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            23: v = 34'sd128;
            24: v = 34'sd64;
            25: v = 34'sd32;
            26: v = 34'sd16;
            27: v = 34'sd8;
            28: v = 34'sd4;
            29: v = 34'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

@@ design/dah_pipe_ctrl.sv @@
// ---------------------------------------------------------------------------
// Pipeline control
// Per-stage valid bits and load enables; empty stages fill up during a stall.
// ---------------------------------------------------------------------------
`default_nettype none

module dah_pipe_ctrl #(
    parameter int N = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire logic         i_ready,
    output logic [N-1:0]      o_en,
    output logic [N-1:0]      o_vld
);
    logic [N-1:0] r_vld;

    assign o_vld = r_vld;

    for (genvar k = 0; k < N; k++) begin : g_stage
        if (k == N - 1) begin : g_last
            assign o_en[k] = !r_vld[k] || i_ready;
        end else begin : g_mid
            assign o_en[k] = !r_vld[k] || o_en[k+1];
        end

        if (k == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (o_en[k]) begin
                    r_vld[k] <= i_valid;
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (o_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ design/dah_isqrt.sv @@
// ---------------------------------------------------------------------------
// Pipelined floor square root
// One result bit per stage by trial subtraction from the running remainder.
// ---------------------------------------------------------------------------
`default_nettype none

module dah_isqrt #(
    parameter int RW = 25
) (
    input  wire logic              i_clk,
    input  wire logic [RW-1:0]     i_en,
    input  wire logic [2*RW-1:0]   i_value,
    output logic [RW-1:0]          o_root
);
    localparam int SQW = 2 * RW;

    logic [SQW-1:0] r_rem  [RW];
    logic [RW-1:0]  r_root [RW];

    for (genvar j = 0; j < RW; j++) begin : g_bit
        localparam int B = RW - 1 - j;

        logic [SQW-1:0] rem_in;
        logic [RW-1:0]  root_in;
        logic [SQW-1:0] trial;
        logic [SQW-1:0] n_rem;
        logic [RW-1:0]  n_root;

        if (j == 0) begin : g_head
            assign rem_in  = i_value;
            assign root_in = '0;
        end else begin : g_tail
            assign rem_in  = r_rem[j-1];
            assign root_in = r_root[j-1];
        end

        assign trial = ({{RW{1'b0}}, root_in} << (B + 1))
                     | ({{(SQW-1){1'b0}}, 1'b1} << (2 * B));

        always_comb begin
            if (rem_in >= trial) begin
                n_rem  = rem_in - trial;
                n_root = root_in | ({{(RW-1){1'b0}}, 1'b1} << B);
            end else begin
                n_rem  = rem_in;
                n_root = root_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[j]) begin
                r_rem[j]  <= n_rem;
                r_root[j] <= n_root;
            end
        end
    end

    assign o_root = r_root[RW-1];

endmodule

`default_nettype wire

@@ design/dah_cordic.sv @@
// ---------------------------------------------------------------------------
// Pipelined vectoring CORDIC
// Quarter-turn pre-rotation, one micro-rotation per stage, final rounding.
// ---------------------------------------------------------------------------
`default_nettype none

module dah_cordic #(
    parameter int COORD_WIDTH     = dah_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = dah_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic [dah_pkg::CORDIC_STEPS+1:0]  i_en,
    input  wire logic signed [COORD_WIDTH:0]       i_dx,
    input  wire logic signed [COORD_WIDTH:0]       i_dz,
    output logic signed [ANGLE_FRAC_BITS+2:0]      o_heading
);
    import dah_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int XW = COORD_WIDTH + PRESCALE_BITS + 3;
    localparam int SH = ACC_FRAC - ANGLE_FRAC_BITS;
    localparam int HW = ANGLE_FRAC_BITS + 3;
    localparam int NS = CORDIC_STEPS;

    logic signed [XW-1:0]        r_x    [NS+1];
    logic signed [XW-1:0]        r_y    [NS+1];
    logic signed [ACC_WIDTH-1:0] r_acc  [NS+1];
    logic                        r_zero [NS+1];
    logic signed [HW-1:0]        r_head;

    logic signed [XW-1:0]        ext_x;
    logic signed [XW-1:0]        ext_z;
    logic signed [XW-1:0]        n_x;
    logic signed [XW-1:0]        n_y;
    logic signed [ACC_WIDTH-1:0] n_acc;
    logic signed [ACC_WIDTH-1:0] rnd;

    assign ext_x = {{(XW-DW){i_dx[DW-1]}}, i_dx} <<< PRESCALE_BITS;
    assign ext_z = {{(XW-DW){i_dz[DW-1]}}, i_dz} <<< PRESCALE_BITS;

    always_comb begin
        if (i_dx[DW-1]) begin
            if (!i_dz[DW-1]) begin
                n_x   = ext_z;
                n_y   = -ext_x;
                n_acc = HALF_PI_Q30;
            end else begin
                n_x   = -ext_z;
                n_y   = ext_x;
                n_acc = -HALF_PI_Q30;
            end
        end else begin
            n_x   = ext_x;
            n_y   = ext_z;
            n_acc = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_x[0]    <= n_x;
            r_y[0]    <= n_y;
            r_acc[0]  <= n_acc;
            r_zero[0] <= (i_dx == '0) && (i_dz == '0);
        end
    end

    for (genvar k = 1; k <= NS; k++) begin : g_iter
        localparam int I = k - 1;
        localparam logic signed [ACC_WIDTH-1:0] ANG = atan_q30(I);

        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;

        assign xs = r_x[k-1] >>> I;
        assign ys = r_y[k-1] >>> I;

        always_ff @(posedge i_clk) begin
            if (i_en[k]) begin
                r_zero[k] <= r_zero[k-1];
                if (!r_y[k-1][XW-1]) begin
                    r_x[k]   <= r_x[k-1] + ys;
                    r_y[k]   <= r_y[k-1] - xs;
                    r_acc[k] <= r_acc[k-1] + ANG;
                end else begin
                    r_x[k]   <= r_x[k-1] - ys;
                    r_y[k]   <= r_y[k-1] + xs;
                    r_acc[k] <= r_acc[k-1] - ANG;
                end
            end
        end
    end

    assign rnd = r_acc[NS] + ({{(ACC_WIDTH-1){1'b0}}, 1'b1} << (SH - 1));

    always_ff @(posedge i_clk) begin
        if (i_en[NS+1]) begin
            r_head <= r_zero[NS] ? '0 : rnd[SH+HW-1:SH];
        end
    end

    assign o_heading = r_head;

endmodule

`default_nettype wire

@@ design/distance_and_heading_unit.sv @@
// ---------------------------------------------------------------------------
// Distance and heading unit
// Distances from a configured reference point (3D and x-z plane, floor
// square root) and the heading atan2(dz, dx) in radians, fully pipelined.
// ---------------------------------------------------------------------------
//  Channel   Direction  Handshake             Payload
//  config    in         i_cfg_wr_en           i_cfg_index, i_cfg_wdata
//  point     in         i_valid / o_ready     i_other_x, i_other_y, i_other_z
//  result    out        o_valid / i_ready     o_distance_3d, o_distance_2d, o_heading
//
//  One beat is accepted per cycle while o_ready is high. At the default width
//  the 30-stage CORDIC chain sets the depth of the pipeline.
//  Reset empties the pipeline and clears the reference point to zero.
//  During an output stall, empty stages keep filling; o_ready falls only when
//  every stage holds a beat.
// ---------------------------------------------------------------------------
`default_nettype none

module distance_and_heading_unit #(
    parameter int COORD_WIDTH     = dah_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = dah_pkg::ANGLE_FRAC_BITS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_wr_en,
    input  wire logic [dah_pkg::CFG_IDX_WIDTH-1:0]    i_cfg_index,
    input  wire logic [COORD_WIDTH-1:0]               i_cfg_wdata,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic signed [COORD_WIDTH-1:0]        i_other_x,
    input  wire logic signed [COORD_WIDTH-1:0]        i_other_y,
    input  wire logic signed [COORD_WIDTH-1:0]        i_other_z,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic [COORD_WIDTH:0]                      o_distance_3d,
    output logic [COORD_WIDTH:0]                      o_distance_2d,
    output logic signed [ANGLE_FRAC_BITS+2:0]         o_heading
);
    import dah_pkg::*;

    localparam int RW      = COORD_WIDTH + 1;
    localparam int SQW     = 2 * RW;
    localparam int HW      = ANGLE_FRAC_BITS + 3;
    localparam int S_SQRT0 = 4;
    localparam int R_END   = S_SQRT0 + RW - 1;
    localparam int C_END   = CORDIC_STEPS + 2;
    localparam int OUT     = ((C_END > R_END) ? C_END : R_END) + 1;
    localparam int NSTG    = OUT + 1;

    logic [NSTG-1:0] en;
    logic [NSTG-1:0] vld;

    logic signed [COORD_WIDTH-1:0] r_own_x;
    logic signed [COORD_WIDTH-1:0] r_own_y;
    logic signed [COORD_WIDTH-1:0] r_own_z;

    logic signed [RW-1:0] r_dx;
    logic signed [RW-1:0] r_dy;
    logic signed [RW-1:0] r_dz;
    logic [RW-1:0]        r_mx;
    logic [RW-1:0]        r_my;
    logic [RW-1:0]        r_mz;
    logic [SQW-1:0]       r_sx;
    logic [SQW-1:0]       r_sy;
    logic [SQW-1:0]       r_sz;
    logic [SQW-1:0]       r_sum2;
    logic [SQW-1:0]       r_sum3;

    logic [RW-1:0]        root3;
    logic [RW-1:0]        root2;
    logic signed [HW-1:0] head;

    logic [RW-1:0]        r_d3 [OUT:R_END+1];
    logic [RW-1:0]        r_d2 [OUT:R_END+1];
    logic signed [HW-1:0] r_dh [OUT:C_END+1];

    dah_pipe_ctrl #(
        .N (NSTG)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_ready (i_ready),
        .o_en    (en),
        .o_vld   (vld)
    );

    assign o_ready = en[0];
    assign o_valid = vld[OUT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_x <= '0;
            r_own_y <= '0;
            r_own_z <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_OWN_X: r_own_x <= i_cfg_wdata;
                REG_OWN_Y: r_own_y <= i_cfg_wdata;
                REG_OWN_Z: r_own_z <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_dx <= {i_other_x[COORD_WIDTH-1], i_other_x} - {r_own_x[COORD_WIDTH-1], r_own_x};
            r_dy <= {i_other_y[COORD_WIDTH-1], i_other_y} - {r_own_y[COORD_WIDTH-1], r_own_y};
            r_dz <= {i_other_z[COORD_WIDTH-1], i_other_z} - {r_own_z[COORD_WIDTH-1], r_own_z};
        end
        if (en[1]) begin
            r_mx <= r_dx[RW-1] ? (~r_dx + 1'b1) : r_dx;
            r_my <= r_dy[RW-1] ? (~r_dy + 1'b1) : r_dy;
            r_mz <= r_dz[RW-1] ? (~r_dz + 1'b1) : r_dz;
        end
        if (en[2]) begin
            r_sx <= r_mx * r_mx;
            r_sy <= r_my * r_my;
            r_sz <= r_mz * r_mz;
        end
        if (en[3]) begin
            r_sum2 <= r_sx + r_sz;
            r_sum3 <= r_sx + r_sy + r_sz;
        end
    end

    dah_isqrt #(
        .RW (RW)
    ) u_root3 (
        .i_clk   (i_clk),
        .i_en    (en[R_END:S_SQRT0]),
        .i_value (r_sum3),
        .o_root  (root3)
    );

    dah_isqrt #(
        .RW (RW)
    ) u_root2 (
        .i_clk   (i_clk),
        .i_en    (en[R_END:S_SQRT0]),
        .i_value (r_sum2),
        .o_root  (root2)
    );

    dah_cordic #(
        .COORD_WIDTH     (COORD_WIDTH),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_cordic (
        .i_clk     (i_clk),
        .i_en      (en[C_END:1]),
        .i_dx      (r_dx),
        .i_dz      (r_dz),
        .o_heading (head)
    );

    for (genvar k = R_END + 1; k <= OUT; k++) begin : g_dist_dly
        if (k == R_END + 1) begin : g_first
            always_ff @(posedge i_clk) begin
                if (en[k]) begin
                    r_d3[k] <= root3;
                    r_d2[k] <= root2;
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (en[k]) begin
                    r_d3[k] <= r_d3[k-1];
                    r_d2[k] <= r_d2[k-1];
                end
            end
        end
    end

    for (genvar k = C_END + 1; k <= OUT; k++) begin : g_head_dly
        if (k == C_END + 1) begin : g_first
            always_ff @(posedge i_clk) begin
                if (en[k]) begin
                    r_dh[k] <= head;
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (en[k]) begin
                    r_dh[k] <= r_dh[k-1];
                end
            end
        end
    end

    assign o_distance_3d = r_d3[OUT];
    assign o_distance_2d = r_d2[OUT];
    assign o_heading     = r_dh[OUT];

endmodule

`default_nettype wire

@@ design/dah_checker.sv @@
// ---------------------------------------------------------------------------
// Distance and heading unit checker
// Port-level properties of the point and result channels, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module dah_checker #(
    parameter int COORD_WIDTH     = dah_pkg::COORD_WIDTH_DEF,
    parameter int ANGLE_FRAC_BITS = dah_pkg::ANGLE_FRAC_BITS_DEF
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            o_ready,
    input wire logic                            o_valid,
    input wire logic                            i_ready,
    input wire logic [COORD_WIDTH:0]            o_distance_3d,
    input wire logic [COORD_WIDTH:0]            o_distance_2d,
    input wire logic [ANGLE_FRAC_BITS+2:0]      o_heading
);

    // A held result must not change while the sink stalls.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_distance_3d)
            && $stable(o_distance_2d) && $stable(o_heading))
        else $error("result changed during stall");

    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_rdy_after_rst: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> o_ready)
        else $error("not ready with an empty pipeline");

    // The planar distance can never exceed the full distance.
    a_dist_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_distance_3d >= o_distance_2d)
        else $error("2D distance above 3D distance");

    // The input side only stalls when the pipeline is full and the sink stalls.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid && !i_ready)
        else $error("input stalled with room in the pipeline");

endmodule

bind distance_and_heading_unit dah_checker #(
    .COORD_WIDTH     (COORD_WIDTH),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_dah_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_ready       (o_ready),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_distance_3d (o_distance_3d),
    .o_distance_2d (o_distance_2d),
    .o_heading     (o_heading)
);

`default_nettype wire

@@ tb/sv/dah_result_checker.sv @@
// ---------------------------------------------------------------------------
// Distance and heading result checker
// Watches the point and result channels and tracks the reference point
// written over the register port. For each accepted point it computes the
// expected distances and heading, and compares every result beat with the
// oldest waiting expectation.
// ---------------------------------------------------------------------------
`default_nettype none

module dah_result_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_wr_en,
    input  wire logic [dah_pkg::CFG_IDX_WIDTH-1:0]  i_cfg_index,
    input  wire logic [23:0]                        i_cfg_wdata,
    input  wire logic                               i_valid,
    input  wire logic                               i_in_ready,
    input  wire logic signed [23:0]                 i_other_x,
    input  wire logic signed [23:0]                 i_other_y,
    input  wire logic signed [23:0]                 i_other_z,
    input  wire logic                               i_out_valid,
    input  wire logic                               i_ready,
    input  wire logic [24:0]                        i_distance_3d,
    input  wire logic [24:0]                        i_distance_2d,
    input  wire logic signed [15:0]                 i_heading,
    output int                                      o_fail_count,
    output int                                      o_pending
);
    import dah_pkg::*;

    typedef struct packed {
        logic [24:0]        dist_3d;
        logic [24:0]        dist_2d;
        logic signed [15:0] heading;
    } t_geo_result;

    logic signed [23:0] ref_x, ref_y, ref_z;
    t_geo_result        expected_q[$];

    function automatic logic [24:0] floor_root(input logic [63:0] v);
        logic [33:0] r;
        logic [33:0] c;
        logic [67:0] sq;
        r = '0;
        for (int b = 33; b >= 0; b--) begin
            c = r | (34'd1 << b);
            sq = c * c;
            if (sq <= {4'd0, v}) r = c;
        end
        return r[24:0];
    endfunction

    function automatic logic signed [15:0] heading_of(input longint dx, input longint dz);
        longint x, y, acc, t, xs, ys;
        if (dx == 0 && dz == 0) return '0;
        x = dx <<< PRESCALE_BITS;
        y = dz <<< PRESCALE_BITS;
        acc = 0;
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y; y = -t; acc = HALF_PI_Q30;
            end else begin
                x = -y; y = t; acc = -HALF_PI_Q30;
            end
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            ys = y >>> i;
            xs = x >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; acc += longint'(atan_q30(i));
            end else begin
                x = x - ys; y = y + xs; acc -= longint'(atan_q30(i));
            end
        end
        acc = (acc + (longint'(1) <<< 16)) >>> 17;
        return acc[15:0];
    endfunction

    function automatic t_geo_result predict_point(input logic signed [23:0] px,
                                                  input logic signed [23:0] py,
                                                  input logic signed [23:0] pz);
        longint dx, dy, dz;
        logic [63:0] plane;
        t_geo_result r;
        dx = longint'(px) - longint'(ref_x);
        dy = longint'(py) - longint'(ref_y);
        dz = longint'(pz) - longint'(ref_z);
        plane = dx * dx + dz * dz;
        r.dist_2d = floor_root(plane);
        r.dist_3d = floor_root(plane + dy * dy);
        r.heading = heading_of(dx, dz);
        return r;
    endfunction

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_geo_result e;
        int errs;
        errs = 0;
        if (!i_rst_n) begin
            ref_x <= '0;
            ref_y <= '0;
            ref_z <= '0;
            o_fail_count <= 0;
            expected_q.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    REG_OWN_X: ref_x <= i_cfg_wdata;
                    REG_OWN_Y: ref_y <= i_cfg_wdata;
                    REG_OWN_Z: ref_z <= i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_valid && i_in_ready)
                expected_q.push_back(predict_point(i_other_x, i_other_y, i_other_z));
            if (i_out_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    $error("unexpected result beat");
                    errs++;
                end else begin
                    e = expected_q.pop_front();
                    if (e.dist_3d !== i_distance_3d) begin
                        $error("distance_3d expected %0d actual %0d", e.dist_3d, i_distance_3d);
                        errs++;
                    end
                    if (e.dist_2d !== i_distance_2d) begin
                        $error("distance_2d expected %0d actual %0d", e.dist_2d, i_distance_2d);
                        errs++;
                    end
                    if (e.heading !== i_heading) begin
                        $error("heading expected %0d actual %0d", e.heading, i_heading);
                        errs++;
                    end
                end
            end
            if (errs != 0) o_fail_count <= o_fail_count + errs;
        end
    end

endmodule

`default_nettype wire

@@ tb/sv/tb_distance_and_heading_unit.sv @@
// ---------------------------------------------------------------------------
// Distance and heading unit testbench
// Drives directed and random points under several references, random idle
// bursts on both channels but the last phase; reports the checker's verdict.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_distance_and_heading_unit;
    import dah_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int LATENCY        = 33;
    localparam int NUM_RANDOM     = 1100;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        i_cfg_wr_en = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]    i_cfg_index = '0;
    logic [23:0]                 i_cfg_wdata = '0;
    logic                        i_valid = 1'b0;
    logic                        o_ready;
    logic signed [23:0]          i_other_x = '0;
    logic signed [23:0]          i_other_y = '0;
    logic signed [23:0]          i_other_z = '0;
    logic                        o_valid;
    logic                        i_ready = 1'b0;
    logic [24:0]                 o_distance_3d;
    logic [24:0]                 o_distance_2d;
    logic signed [15:0]          o_heading;
    int                          fail_count;
    int                          pending;
    int                          idle_cycles;
    bit                          stalls_on = 1'b1;

    distance_and_heading_unit dut (.*);

    dah_result_checker u_checker (
        .i_clk, .i_rst_n, .i_cfg_wr_en, .i_cfg_index, .i_cfg_wdata,
        .i_valid, .i_in_ready(o_ready), .i_other_x, .i_other_y, .i_other_z,
        .i_out_valid(o_valid), .i_ready, .i_distance_3d(o_distance_3d),
        .i_distance_2d(o_distance_2d), .i_heading(o_heading),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Ready to the unit goes on and off in random bursts while stalls_on is set.
    initial begin
        int n;
        @(posedge i_clk);
        forever begin
            n = $urandom_range(1, 19);
            i_ready <= (!stalls_on) || ($urandom_range(0, 2) != 0);
            repeat (n) @(posedge i_clk);
        end
    end

    task automatic write_reg(input t_reg_idx idx, input logic [23:0] v);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic set_reference(input logic [23:0] x, input logic [23:0] y,
                                 input logic [23:0] z);
        write_reg(REG_OWN_X, x);
        write_reg(REG_OWN_Y, y);
        write_reg(REG_OWN_Z, z);
    endtask

    task automatic send_point(input logic [23:0] x, input logic [23:0] y,
                              input logic [23:0] z);
        if (stalls_on && $urandom_range(0, 7) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_other_x <= x;
        i_other_y <= y;
        i_other_z <= z;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic [23:0] random_coord();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 511)) - 24'd256;
            1: return 24'($urandom_range(0, 65535)) - 24'd32768;
            default: return 24'($urandom);
        endcase
    endfunction

    localparam logic [23:0] CMAX = 24'h7FFFFF;
    localparam logic [23:0] CMIN = 24'h800000;

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed points with the reference at the origin.
        send_point('0, '0, '0);
        send_point(-24'd5, '0, '0);
        send_point(24'd5, '0, '0);
        send_point('0, '0, 24'd7);
        send_point('0, '0, -24'd7);
        send_point(-24'd3, 24'd9, 24'd3);
        send_point(-24'd3, 24'd1, -24'd3);
        send_point(CMAX, CMAX, CMAX);
        send_point(CMIN, CMIN, CMIN);
        send_point(CMIN, '0, '0);
        send_point(CMAX, CMIN, CMIN);
        send_point(24'hFFFFFF, 24'h555555, 24'hAAAAAA);
        drain_results();

        // Opposite extremes give the largest distances.
        set_reference(CMIN, CMIN, CMIN);
        send_point(CMAX, CMAX, CMAX);
        send_point(CMIN, CMIN, CMIN);
        send_point(CMAX, CMIN, CMIN);
        send_point(CMIN, CMIN, CMAX);
        drain_results();
        set_reference(CMAX, CMAX, CMAX);
        send_point(CMIN, CMIN, CMIN);
        send_point(CMIN, CMAX, CMAX);
        send_point(CMAX, CMIN, CMIN);
        drain_results();

        for (int phase = 0; phase < 5; phase++) begin
            set_reference(random_coord(), random_coord(), random_coord());
            if (phase == 4) stalls_on = 1'b0;
            for (int k = 0; k < NUM_RANDOM / 5; k++) begin
                if ($urandom_range(0, 9) == 0)
                    send_point(i_other_x, random_coord(), i_other_z);
                else
                    send_point(random_coord(), random_coord(), random_coord());
            end
            drain_results();
        end

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
design/dah_pkg.sv
design/dah_pipe_ctrl.sv
design/dah_isqrt.sv
design/dah_cordic.sv
design/distance_and_heading_unit.sv
design/dah_checker.sv
tb/sv/dah_result_checker.sv
tb/sv/tb_distance_and_heading_unit.sv
